// File: hw/rtl/srve_pkg.sv
`timescale 1ns / 1ps
// Package for the signed run-length varint encoder.
// Holds the default parameters, the result limit and the sequencer state type.
package srve_pkg;

  localparam int DefRunLimit  = 3;
  localparam int DefValueBits = 32;
  localparam int MaxResults   = 48;
  localparam int CountBits    = $clog2(MaxResults + 1);

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_DATA = 3'b010,
    PH_END  = 3'b100
  } phase_t;

endpackage

// File: hw/rtl/signed_runlength_varint_encoder_unit.sv
`timescale 1ns / 1ps
// Signed run-length varint encoder: one signed value in, its self-terminating
// code out one bit per item, LSB first. Depends on srve_pkg.
//
// Input channel (in_valid / in_stall / value): one signed value per item.
// Output channel (out_valid / out_stall / code_bit / final_bit): one code bit
// per item; final_bit marks the last bit of a value's code.
//
// A single shift-and-emit step is reused once per cycle, unless the output
// stalls, under a small sequencer: each step either shifts one data bit out
// of the value, inserts an escape bit after a run of RUN_LIMIT equal bits, or
// writes an end-marker bit. Switching from data to end marker is a step that
// emits no bit. An item of N code bits occupies the sequencer from acceptance
// until its final bit is loaded; with the defaults N is at most 45. The first
// bit comes from the first data step after acceptance; for zero and minus one
// it is an end-marker bit, after the switch. in_stall is high while an item
// is being encoded and drops as the final bit is loaded, so a new value waits
// until the last one is done. A stall on the output freezes the sequencer; the
// output register holds its bit until it is taken. Codes longer than
// MaxResults bits are cut, and the last kept bit carries final_bit.
// Reset (rst, synchronous) returns the sequencer to idle and empties the
// output register.
module signed_runlength_varint_encoder_unit
  import srve_pkg::*;
#(
  parameter int RUN_LIMIT  = DefRunLimit,
  parameter int VALUE_BITS = DefValueBits
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [VALUE_BITS-1:0] value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         code_bit,
  output logic                         final_bit
);

  localparam int RunBits = RUN_LIMIT + 1;

  phase_t                 phase, phase_next;
  logic [VALUE_BITS-1:0]  rem, rem_next;
  logic [RunBits-1:0]     run, run_next;
  logic                   last, last_next;
  logic [CountBits-1:0]   count, count_next;

  logic                   emit;
  logic                   emit_bit;
  logic                   emit_final;
  logic                   can_emit;
  logic                   done_data;
  logic                   run_full;
  logic                   pol;
  logic                   in_take;

  assign in_stall  = (phase != PH_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign can_emit  = !out_valid || !out_stall;
  assign done_data = (rem == '0) || (rem == '1);
  assign run_full  = run[RUN_LIMIT];
  assign pol       = rem[0];

  always_comb begin
    phase_next = phase;
    rem_next   = rem;
    run_next   = run;
    last_next  = last;
    count_next = count;
    emit       = 1'b0;
    emit_bit   = 1'b0;
    emit_final = 1'b0;

    case (phase)
      PH_IDLE: begin
        if (in_take) begin
          rem_next   = value;
          run_next   = RunBits'(1);
          last_next  = 1'b0;
          count_next = '0;
          phase_next = PH_DATA;
        end
      end
      PH_DATA: begin
        if (can_emit) begin
          if (done_data) begin
            phase_next = PH_END;
          end else if (run_full) begin
            // escape bit of opposite polarity, run restarts
            emit     = 1'b1;
            emit_bit = ~last;
            run_next = RunBits'(1);
          end else begin
            emit      = 1'b1;
            emit_bit  = rem[0];
            rem_next  = {rem[VALUE_BITS-1], rem[VALUE_BITS-1:1]};
            last_next = rem[0];
            run_next  = (last ^ rem[0]) ? RunBits'(2) : (run << 1);
          end
        end
      end
      PH_END: begin
        if (can_emit) begin
          emit = 1'b1;
          if (run_full && (last == pol)) begin
            emit_bit   = pol;
            emit_final = 1'b1;
          end else if (run_full) begin
            emit_bit = ~last;
            run_next = RunBits'(1);
          end else begin
            emit      = 1'b1;
            emit_bit  = pol;
            last_next = pol;
            run_next  = (last ^ pol) ? RunBits'(2) : (run << 1);
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    if (emit) begin
      count_next = count + CountBits'(1);
      // the last slot always closes the code
      if (count == CountBits'(MaxResults - 1)) begin
        emit_final = 1'b1;
      end
      if (emit_final) begin
        phase_next = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      rem   <= '0;
      run   <= RunBits'(1);
      last  <= 1'b0;
      count <= '0;
    end else begin
      phase <= phase_next;
      rem   <= rem_next;
      run   <= run_next;
      last  <= last_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (emit) begin
      code_bit  <= emit_bit;
      final_bit <= emit_final;
    end
  end

  a_take_starts_data: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (phase == PH_DATA))
    else $error("accepted item did not start data phase");

  a_run_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(run))
    else $error("run counter not one-hot");

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    count <= CountBits'(MaxResults))
    else $error("result count beyond limit");

  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_IDLE && out_valid && out_stall) |=> $stable(rem) && $stable(run))
    else $error("sequencer moved while output stalled");

endmodule
